@@ rtl/bis_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the byte insertion sorter.
// ----------------------------------------------------------------------------
package bis_pkg;

  // default depth of the sorted store
  localparam int MAX_ITEMS_DEF = 64;

  // one input transaction
  typedef struct packed {
    logic signed [7:0] value;
    logic              last_in;
  } in_item_t;

  // one output transaction
  typedef struct packed {
    logic signed [7:0] sorted_value;
    logic              last_out;
    logic              overflow;
  } out_item_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_PLACE,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/bis_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_store
// Sorted store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bis_store #(
  parameter int MAX_ITEMS = bis_pkg::MAX_ITEMS_DEF,
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [7:0]    wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [7:0]    rd_data
);

  logic signed [7:0] mem [MAX_ITEMS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/byte_insertion_sorter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_insertion_sorter
// Stable insertion sort of a run of signed bytes, emitted on the last item.
// ----------------------------------------------------------------------------
// Each input transaction is inserted into a sorted store of MAX_ITEMS bytes by
// one compare-and-shift step per cycle, walking down from the top entry: an
// item that finds the store empty is written straight to the bottom, one that
// finds it full is dropped and overflow is raised, and otherwise each stored
// entry that the item goes before moves up one place (at most MAX_ITEMS - 1
// entries). in_stall is high for the whole insertion. When the transaction
// carrying last_in has been taken in, the stored run is sent out in order, one
// transaction per cycle while out_stall is low, the final one with last_out
// set; the run then restarts empty. The descending bit selects the sort order
// and must be written by the user only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module byte_insertion_sorter #(
  parameter int MAX_ITEMS = bis_pkg::MAX_ITEMS_DEF,
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
  localparam int CW = $clog2(MAX_ITEMS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bis_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bis_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

  bis_pkg::state_t   state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     pos, pos_next;
  logic [CW-1:0]     emit_idx, emit_idx_next;
  logic              dropped, dropped_next;
  logic              descending;
  logic signed [7:0] cur_value, cur_value_next;
  logic              cur_last, cur_last_next;
  logic              rd_pending, rd_pending_next;
  logic              rd_last, rd_last_next;

  logic              in_accept;
  logic              out_accept;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic signed [7:0] wr_data;
  logic              rd_en;
  logic [CW-1:0]     rd_idx;
  logic signed [7:0] rd_data;
  logic              goes_after;
  logic              emit_load;
  logic              insert_done;

  assign in_stall   = (state != bis_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // shared compare unit
  assign goes_after = descending ? (rd_data < cur_value) : (rd_data > cur_value);

  // output register free or freed this cycle
  assign emit_load = rd_pending && (!out_valid || !out_stall);

  // store
  bis_store #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bis_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (count >= FULL || count == '0) begin
            state_next = in_data.last_in ? bis_pkg::ST_EMIT : bis_pkg::ST_IDLE;
          end else begin
            state_next = bis_pkg::ST_CMP;
          end
        end
      end
      bis_pkg::ST_CMP: begin
        if (goes_after) begin
          if (pos == CW'(1)) begin
            state_next = bis_pkg::ST_PLACE;
          end
        end else begin
          state_next = cur_last ? bis_pkg::ST_EMIT : bis_pkg::ST_IDLE;
        end
      end
      bis_pkg::ST_PLACE: begin
        state_next = cur_last ? bis_pkg::ST_EMIT : bis_pkg::ST_IDLE;
      end
      bis_pkg::ST_EMIT: begin
        if (emit_idx == count && !rd_pending) begin
          state_next = bis_pkg::ST_IDLE;
        end
      end
      default: state_next = bis_pkg::ST_IDLE;
    endcase
  end

  // datapath control and register next values
  always_comb begin
    count_next      = count;
    pos_next        = pos;
    emit_idx_next   = emit_idx;
    dropped_next    = dropped;
    cur_value_next  = cur_value;
    cur_last_next   = cur_last;
    rd_pending_next = rd_pending;
    rd_last_next    = rd_last;
    wr_en           = 1'b0;
    wr_addr         = pos[AW-1:0];
    wr_data         = cur_value;
    rd_en           = 1'b0;
    rd_idx          = CW'(pos - CW'(2));
    insert_done     = 1'b0;
    unique case (state)
      bis_pkg::ST_IDLE: begin
        rd_idx = CW'(count - CW'(1));
        if (in_accept) begin
          cur_value_next = in_data.value;
          cur_last_next  = in_data.last_in;
          emit_idx_next  = '0;
          if (count >= FULL) begin
            // store full: drop the item
            dropped_next = 1'b1;
          end else if (count == '0) begin
            // first item goes straight to the bottom
            wr_en      = 1'b1;
            wr_addr    = '0;
            wr_data    = in_data.value;
            count_next = CW'(1);
          end else begin
            // fetch the top entry to start the walk down
            rd_en    = 1'b1;
            pos_next = count;
          end
        end
      end
      bis_pkg::ST_CMP: begin
        if (goes_after) begin
          // move the entry up one place
          wr_en    = 1'b1;
          wr_data  = rd_data;
          pos_next = CW'(pos - CW'(1));
          rd_en    = (pos != CW'(1));
        end else begin
          wr_en       = 1'b1;
          insert_done = 1'b1;
        end
      end
      bis_pkg::ST_PLACE: begin
        wr_en       = 1'b1;
        insert_done = 1'b1;
      end
      bis_pkg::ST_EMIT: begin
        rd_idx = emit_idx;
        if (emit_load) begin
          rd_pending_next = 1'b0;
        end
        if (emit_idx != count && (!rd_pending || emit_load)) begin
          rd_en           = 1'b1;
          rd_pending_next = 1'b1;
          rd_last_next    = (CW'(emit_idx + CW'(1)) == count);
          emit_idx_next   = CW'(emit_idx + CW'(1));
        end
        if (emit_idx == count && !rd_pending) begin
          count_next   = '0;
          dropped_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (insert_done) begin
      count_next = CW'(count + CW'(1));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bis_pkg::ST_IDLE;
      count      <= '0;
      dropped    <= 1'b0;
      descending <= 1'b0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      dropped    <= dropped_next;
      rd_pending <= rd_pending_next;
      if (cfg_wr_en) begin
        descending <= cfg_wr_data;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_accept) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos       <= pos_next;
    emit_idx  <= emit_idx_next;
    cur_value <= cur_value_next;
    cur_last  <= cur_last_next;
    rd_last   <= rd_last_next;
    if (emit_load) begin
      out_data.sorted_value <= rd_data;
      out_data.last_out     <= rd_last;
      out_data.overflow     <= dropped;
    end
  end

endmodule
